// ----- sv/bpc_pkg.sv -----
package bpc_pkg;

    // Event codes carried in event_res and held as the pending event
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_SHORT = 2'd1;
    localparam logic [1:0] EV_LONG  = 2'd2;

    // Request kinds
    localparam logic KIND_TAKE = 1'b0;
    localparam logic KIND_PEEK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_BUTTON_BIT    = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE_TIME = 2'd1;
    localparam logic [1:0] CFG_LONG_TIME     = 2'd2;

    // Configuration reset values
    localparam logic [2:0]  BUTTON_BIT_RST    = 3'd0;
    localparam logic [15:0] DEBOUNCE_TIME_RST = 16'd25;
    localparam logic [15:0] LONG_TIME_RST     = 16'd600;

    typedef struct packed {
        logic [2:0]  button_bit;
        logic [15:0] debounce_time;
        logic [15:0] long_time;
    } t_cfg;

endpackage

// ----- sv/bpc_in_if.sv -----
interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  port_byte;
    logic [31:0] timestamp;

    modport source (output valid, output kind, output port_byte, output timestamp,
                    input ready);
    modport sink   (input valid, input kind, input port_byte, input timestamp,
                    output ready);
endinterface

// ----- sv/bpc_out_if.sv -----
interface bpc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic       pressed;

    modport source (output valid, output event_res, output pressed, input ready);
    modport sink   (input valid, input event_res, input pressed, output ready);
endinterface

// ----- sv/bpc_core.sv -----
module bpc_core import bpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_cfg        i_cfg,
    input  logic        i_kind,
    input  logic [7:0]  i_port_byte,
    input  logic [31:0] i_timestamp,
    output logic [1:0]  o_event_res,
    output logic        o_pressed
);

    logic        r_last_raw;
    logic [31:0] r_change_time;
    logic        r_stable;
    logic [31:0] r_press_start;
    logic        r_long_done;
    logic [1:0]  r_pending;

    logic        n_last_raw;
    logic [31:0] n_change_time;
    logic        n_stable;
    logic [31:0] n_press_start;
    logic        n_long_done;
    logic [1:0]  n_pending;

    logic        raw;
    logic [31:0] since_change;
    logic [31:0] since_press;
    logic [1:0]  polled_event;

    // Debounce, then classify the press
    always_comb begin
        raw           = ~i_port_byte[i_cfg.button_bit];
        since_change  = i_timestamp - r_change_time;
        n_last_raw    = r_last_raw;
        n_change_time = r_change_time;
        n_stable      = r_stable;
        n_press_start = r_press_start;
        n_long_done   = r_long_done;
        polled_event  = r_pending;

        if (raw != r_last_raw) begin
            n_last_raw    = raw;
            n_change_time = i_timestamp;
        end else if (since_change >= {16'd0, i_cfg.debounce_time} && raw != r_stable) begin
            n_stable = raw;
            if (raw) begin
                n_press_start = i_timestamp;
                n_long_done   = 1'b0;
            end else if (!r_long_done) begin
                polled_event = EV_SHORT;
            end
        end

        // Fire one long event per press
        since_press = i_timestamp - n_press_start;
        if (n_stable && !n_long_done && since_press >= {16'd0, i_cfg.long_time}) begin
            n_long_done  = 1'b1;
            polled_event = EV_LONG;
        end

        // Take or keep the pending event
        if (i_kind == KIND_TAKE) begin
            o_event_res = polled_event;
            n_pending   = EV_NONE;
        end else begin
            o_event_res = EV_NONE;
            n_pending   = polled_event;
        end
        o_pressed = n_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= 1'b0;
            r_change_time <= 32'd0;
            r_stable      <= 1'b0;
            r_press_start <= 32'd0;
            r_long_done   <= 1'b0;
            r_pending     <= EV_NONE;
        end else if (i_step) begin
            r_last_raw    <= n_last_raw;
            r_change_time <= n_change_time;
            r_stable      <= n_stable;
            r_press_start <= n_press_start;
            r_long_done   <= n_long_done;
            r_pending     <= n_pending;
        end
    end

endmodule

// ----- sv/button_press_classifier_top.sv -----
// Button press classifier: debounces one active-low button bit of an
// expander port byte and reports short and long presses.
//
// Channels: i_req carries one poll request (kind, port_byte, timestamp);
// o_res returns exactly one result (event_res, pressed) per request, in
// order. Both use valid/ready; a transfer happens when both are high.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data (index 0
// button bit, 1 debounce time, 2 long time) by the user while the block is
// idle; the block itself does not enforce this.
//
// Pipeline: a request passes one input register, then one result register.
// Throughput: one request per cycle while the receiver is not stalling; the
// debounce and classify logic between the two registers is combinational.
//
// Reset clears the button state and pending event and loads the default
// configuration (bit 0, 25 ms debounce, 600 ms long press).
// When the receiver stalls, the result holds in the output register, one
// more request is held in the input register, and i_req.ready then drops.
module button_press_classifier_top import bpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bpc_in_if.sink      i_req,
    bpc_out_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cfg        r_cfg;

    logic        r_in_valid;
    logic        r_in_kind;
    logic [7:0]  r_in_port_byte;
    logic [31:0] r_in_timestamp;

    logic        r_out_valid;
    logic [1:0]  r_out_event_res;
    logic        r_out_pressed;

    logic        out_free;
    logic        step;
    logic [1:0]  core_event_res;
    logic        core_pressed;

    assign out_free    = !r_out_valid || o_res.ready;
    assign step        = r_in_valid && out_free;
    assign i_req.ready = !r_in_valid || out_free;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_bit    <= BUTTON_BIT_RST;
            r_cfg.debounce_time <= DEBOUNCE_TIME_RST;
            r_cfg.long_time     <= LONG_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BUTTON_BIT:    r_cfg.button_bit    <= i_cfg_data[2:0];
                CFG_DEBOUNCE_TIME: r_cfg.debounce_time <= i_cfg_data;
                CFG_LONG_TIME:     r_cfg.long_time     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_kind      <= i_req.kind;
            r_in_port_byte <= i_req.port_byte;
            r_in_timestamp <= i_req.timestamp;
        end
    end

    bpc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_cfg       (r_cfg),
        .i_kind      (r_in_kind),
        .i_port_byte (r_in_port_byte),
        .i_timestamp (r_in_timestamp),
        .o_event_res (core_event_res),
        .o_pressed   (core_pressed)
    );

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_event_res <= core_event_res;
            r_out_pressed   <= core_pressed;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.event_res = r_out_event_res;
    assign o_res.pressed   = r_out_pressed;

endmodule

// ----- sv/bpc_checker.sv -----
module bpc_checker import bpc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_event_res
);

    // No result is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A free output side never blocks a request
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("request blocked while output side is free");

    // Only defined event codes leave the block
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_event_res == EV_NONE || i_out_event_res == EV_SHORT ||
                         i_out_event_res == EV_LONG))
        else $error("undefined event code");

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind button_press_classifier_top bpc_checker u_bpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_req.ready),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_out_event_res (o_res.event_res)
);
